FILE: sv/pca_pkg.sv
// Shared widths, constants and types of the pixel color adjust chain.
package pca_pkg;

    // Register port
    localparam int DATA_W    = 32;
    localparam int ADDR_W    = 5;
    localparam int REG_IDX_W = ADDR_W - 2;

    localparam logic [REG_IDX_W-1:0] REG_ENABLE   = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_GAMMA    = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_BRIGHT   = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_CONTRAST = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_VIBRANCE = 3'd4;

    localparam int EN_GAMMA    = 0;
    localparam int EN_DESAT    = 1;
    localparam int EN_BRIGHT   = 2;
    localparam int EN_CONTRAST = 3;
    localparam int EN_VIB      = 4;

    // Pixel and register fields
    localparam int NUM_CH = 3;
    localparam int CH_W   = 8;
    localparam int FRAC_W = 8;
    localparam int Q8_W   = CH_W + FRAC_W;
    localparam int MASK_W = 5;
    localparam int GAIN_W = 10;
    localparam int VIB_W  = 13;
    localparam int GSQ_W  = 2 * GAIN_W;

    // Datapath widths, sized to the value ranges of each step
    localparam int DIV_SH = 16;
    localparam int GP_W   = Q8_W + GSQ_W;
    localparam int GAM_W  = 21;
    localparam int LW_W   = 16;
    localparam int DP_W   = GAM_W + LW_W;
    localparam int BP_W   = GAM_W + GAIN_W;
    localparam int BRT_W  = 23;
    localparam int CD_W   = BRT_W + 1;
    localparam int CP_W   = CD_W + GAIN_W + 1;
    localparam int XF_W   = 26;
    localparam int DIFF_W = 25;
    localparam int D3_W   = 26;
    localparam int P_W    = DIFF_W + D3_W;
    localparam int AV_W   = VIB_W;
    localparam int PL_W   = 26;
    localparam int N_W    = 64;
    localparam int TF_W   = N_W - DIV_SH;
    localparam int T_W    = 38;
    localparam int TL_W   = 32;
    localparam int Q_W    = 26;
    localparam int MAG_W  = Q_W + 1;
    localparam int NC_W   = MAG_W + 2;
    localparam int RCP_SH = 38;
    localparam int RCP_W  = 27;

    localparam int MID_Q8 = 32640;

    // Luma weights in Q.16, red/green/blue
    localparam logic [LW_W-1:0] LUMA [NUM_CH] = '{16'd19661, 16'd38666, 16'd7209};

    // Vibrance divisor is 3 * 256 * 256 * 1275 = 2^16 * 3825
    localparam logic [11:0]          DIV_K    = 12'd3825;
    localparam logic [N_W-1:0]       VIB_HALF = 64'd3825 << (DIV_SH - 1);
    localparam logic [TF_W-1:0]      T_SAT    = 48'd3825 << Q_W;
    localparam logic [RCP_W-1:0]     RECIP    = RCP_W'((64'd1 << RCP_SH) / 64'd3825);
    localparam logic [MAG_W-1:0]     MAG_SAT  = MAG_W'(1) << Q_W;

    // Pipeline depth: seven front stages, six vibrance lane stages, output
    localparam int LANE_ST = 6;
    localparam int NST     = 14;

    typedef struct packed {
        logic [LANE_ST-1:0] en;
        logic [LANE_ST-1:0] vld;
    } pca_lane_ctl_t;

endpackage

FILE: sv/pca_vib_lane.sv
// Vibrance magnitude lane: round(diff * d3 * |V| / 250675200), six register stages.
module pca_vib_lane (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  pca_pkg::pca_lane_ctl_t        ctl,
    input  logic [pca_pkg::DIFF_W-1:0]    diff,
    input  logic [pca_pkg::D3_W-1:0]      d3,
    input  logic [pca_pkg::AV_W-1:0]      vib_abs,
    output logic [pca_pkg::MAG_W-1:0]     mag
);
    import pca_pkg::*;

    localparam int LO_W = PL_W + AV_W;
    localparam int HI_W = P_W - PL_W + AV_W;
    localparam int PLO_W = TL_W + RCP_W;
    localparam int PHI_W = T_W - TL_W + RCP_W;

    logic [P_W-1:0]   p_reg;
    logic [LO_W-1:0]  lo_reg;
    logic [HI_W-1:0]  hi_reg;
    logic [T_W-1:0]   t_j_reg, t_k_reg, t_l_reg;
    logic             sat_j_reg, sat_k_reg, sat_l_reg;
    logic [PLO_W-1:0] plo_reg;
    logic [PHI_W-1:0] phi_reg;
    logic [Q_W-1:0]   qe_l_reg;
    logic [MAG_W-1:0] mag_reg;

    logic [N_W-1:0]   nsum;
    logic [TF_W-1:0]  t_full;
    logic [N_W-1:0]   psum;
    logic [T_W-1:0]   qk;
    logic [T_W-1:0]   rem;
    logic [MAG_W-1:0] q_fix;

    always_comb begin
        nsum   = (N_W'(hi_reg) << PL_W) + N_W'(lo_reg) + VIB_HALF;
        t_full = nsum[N_W-1:DIV_SH];
        psum   = (N_W'(phi_reg) << TL_W) + N_W'(plo_reg);
        qk     = T_W'(qe_l_reg) * T_W'(DIV_K);
        rem    = t_l_reg - qk;
        // reciprocal estimate is low by at most one
        q_fix  = (rem >= T_W'(DIV_K)) ? MAG_W'(qe_l_reg) + MAG_W'(1) : MAG_W'(qe_l_reg);
    end

    always_ff @(posedge aclk) begin
        if (ctl.en[0]) begin
            p_reg <= P_W'(diff) * P_W'(d3);
        end
        if (ctl.en[1]) begin
            lo_reg <= LO_W'(p_reg[PL_W-1:0]) * LO_W'(vib_abs);
            hi_reg <= HI_W'(p_reg[P_W-1:PL_W]) * HI_W'(vib_abs);
        end
        if (ctl.en[2]) begin
            t_j_reg   <= t_full[T_W-1:0];
            sat_j_reg <= (t_full >= T_SAT);
        end
        if (ctl.en[3]) begin
            plo_reg   <= PLO_W'(t_j_reg[TL_W-1:0]) * PLO_W'(RECIP);
            phi_reg   <= PHI_W'(t_j_reg[T_W-1:TL_W]) * PHI_W'(RECIP);
            t_k_reg   <= t_j_reg;
            sat_k_reg <= sat_j_reg;
        end
        if (ctl.en[4]) begin
            qe_l_reg  <= psum[RCP_SH +: Q_W];
            t_l_reg   <= t_k_reg;
            sat_l_reg <= sat_k_reg;
        end
        if (ctl.en[5]) begin
            mag_reg <= sat_l_reg ? MAG_SAT : q_fix;
        end
    end

    assign mag = mag_reg;

    a_qest_not_high: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.vld[4] && !sat_l_reg |-> qk <= t_l_reg)
        else $error("vibrance quotient estimate above true quotient");

    a_qest_within_one: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.vld[4] && !sat_l_reg |-> rem < (T_W'(DIV_K) << 1))
        else $error("vibrance quotient estimate off by more than one");

endmodule

FILE: sv/pixel_color_adjust_chain_core.sv
// Top level of the pixel color adjust chain: registers, 14-stage datapath, handshakes.
// Throughput: one pixel per cycle while m_ready keeps the output moving;
// every stage is a register with its own valid bit.
// The depth is set by the vibrance path: one product, a split product by |V| and a
// reciprocal divide by 3825 with a one-step correction, each behind its own register.
// Reset (aresetn low, synchronous) clears all valid bits and loads register defaults.
module pixel_color_adjust_chain_core (
    input  logic                         aclk,
    input  logic                         aresetn,
    // configuration port
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [pca_pkg::ADDR_W-1:0]   paddr,
    input  logic [pca_pkg::DATA_W-1:0]   pwdata,
    output logic [pca_pkg::DATA_W-1:0]   prdata,
    output logic                         pready,
    // pixel input
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [pca_pkg::CH_W-1:0]     s_red_in,
    input  logic [pca_pkg::CH_W-1:0]     s_green_in,
    input  logic [pca_pkg::CH_W-1:0]     s_blue_in,
    input  logic                         s_last_in,
    // pixel output
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [pca_pkg::CH_W-1:0]     m_red_out,
    output logic [pca_pkg::CH_W-1:0]     m_green_out,
    output logic [pca_pkg::CH_W-1:0]     m_blue_out,
    output logic                         m_last_out
);
    import pca_pkg::*;

    // Stage map
    localparam int ST_GAMMA  = 0;  // gamma product
    localparam int ST_DESAT  = 1;  // gamma round, luma products
    localparam int ST_MIX    = 2;  // luma sum, desaturate select
    localparam int ST_BRIGHT = 3;  // brightness product
    localparam int ST_CONTR  = 4;  // brightness round, contrast product
    localparam int ST_CRND   = 5;  // contrast round, re-center
    localparam int ST_VSETUP = 6;  // max, d3, per-channel distance
    localparam int ST_LANE   = 7;  // first of the vibrance lane stages
    localparam int ST_OUT    = NST - 1;

    localparam logic [GP_W:0]          GP_HALF = (GP_W+1)'(1) << (DIV_SH - 1);
    localparam logic [DP_W:0]          DP_HALF = (DP_W+1)'(1) << (DIV_SH - 1);
    localparam logic [BP_W:0]          BP_HALF = (BP_W+1)'(1) << (FRAC_W - 1);
    localparam logic signed [CD_W-1:0] CD_MID  = CD_W'(MID_Q8);
    localparam logic signed [CP_W-1:0] CP_MID  = CP_W'(MID_Q8);
    localparam logic signed [CP_W-1:0] CP_HALF = CP_W'(1) << (FRAC_W - 1);
    localparam logic signed [NC_W-1:0] NC_HALF = NC_W'(1) << (FRAC_W - 1);

    // ------------------------------------------------------------------
    // Configuration registers. The gamma square is captured with the
    // write so the first pipeline stage sees a ready-made Q.16 factor.
    // ------------------------------------------------------------------
    logic [MASK_W-1:0] mask_reg;
    logic [GAIN_W-1:0] gamma_reg;
    logic [GSQ_W-1:0]  gsq_reg;
    logic [GAIN_W-1:0] bgain_reg;
    logic [GAIN_W-1:0] cgain_reg;
    logic [VIB_W-1:0]  vib_reg;

    logic                 cfg_wr;
    logic [REG_IDX_W-1:0] cfg_idx;
    logic [GAIN_W-1:0]    wr_gain;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[ADDR_W-1:2];
    assign wr_gain = pwdata[GAIN_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mask_reg  <= '0;
            gamma_reg <= GAIN_W'(256);
            gsq_reg   <= GSQ_W'(65536);
            bgain_reg <= GAIN_W'(256);
            cgain_reg <= GAIN_W'(256);
            vib_reg   <= '0;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_ENABLE: begin
                    mask_reg <= pwdata[MASK_W-1:0];
                end
                REG_GAMMA: begin
                    gamma_reg <= wr_gain;
                    gsq_reg   <= GSQ_W'(wr_gain) * GSQ_W'(wr_gain);
                end
                REG_BRIGHT: begin
                    bgain_reg <= wr_gain;
                end
                REG_CONTRAST: begin
                    cgain_reg <= wr_gain;
                end
                REG_VIBRANCE: begin
                    vib_reg <= pwdata[VIB_W-1:0];
                end
                default: begin
                    // addresses past the register list are ignored
                end
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_ENABLE:   prdata = DATA_W'(mask_reg);
            REG_GAMMA:    prdata = DATA_W'(gamma_reg);
            REG_BRIGHT:   prdata = DATA_W'(bgain_reg);
            REG_CONTRAST: prdata = DATA_W'(cgain_reg);
            REG_VIBRANCE: prdata = DATA_W'(vib_reg);
            default:      prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Pipeline control. Each stage advances when it is empty or when the
    // stage after it advances, so bubbles collapse and the input keeps
    // taking transactions while a finished pixel waits at the output.
    // ------------------------------------------------------------------
    logic [NST-1:0] vld_reg;
    logic [NST-1:0] vld_shift;
    logic [NST-1:0] en;
    logic [NST-1:0] last_reg;
    logic [NST-1:0] last_shift;

    always_comb begin
        en[ST_OUT] = !vld_reg[ST_OUT] || m_ready;
        for (int k = ST_OUT - 1; k >= 0; k--) begin
            en[k] = !vld_reg[k] || en[k+1];
        end
    end

    assign vld_shift  = {vld_reg[NST-2:0], s_valid};
    assign last_shift = {last_reg[NST-2:0], s_last_in};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            for (int k = 0; k < NST; k++) begin
                if (en[k]) begin
                    vld_reg[k] <= vld_shift[k];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int k = 0; k < NST; k++) begin
            if (en[k]) begin
                last_reg[k] <= last_shift[k];
            end
        end
    end

    assign s_ready    = en[ST_GAMMA];
    assign m_valid    = vld_reg[ST_OUT];
    assign m_last_out = last_reg[ST_OUT];

    // ------------------------------------------------------------------
    // Datapath. A disabled step still runs through its stage with a
    // bypass value scaled so the following round gives back the input.
    // ------------------------------------------------------------------
    logic [CH_W-1:0] pix_in [NUM_CH];
    assign pix_in[0] = s_red_in;
    assign pix_in[1] = s_green_in;
    assign pix_in[2] = s_blue_in;

    logic [GP_W-1:0]         gp_reg   [NUM_CH];
    logic [GAM_W-1:0]        gam_reg  [NUM_CH];
    logic [DP_W-1:0]         dp_reg   [NUM_CH];
    logic [GAM_W-1:0]        xc_reg   [NUM_CH];
    logic [BP_W-1:0]         bp_reg   [NUM_CH];
    logic signed [CP_W-1:0]  cp_reg   [NUM_CH];
    logic signed [XF_W-1:0]  xf_reg   [NUM_CH];
    logic [DIFF_W-1:0]       diff_reg [NUM_CH];
    logic [D3_W-1:0]         d3_reg;
    logic signed [XF_W-1:0]  cv_reg   [LANE_ST+1][NUM_CH];
    logic [CH_W-1:0]         out_reg  [NUM_CH];

    logic [GP_W-1:0]         gp_next  [NUM_CH];
    logic [GAM_W-1:0]        gam_next [NUM_CH];
    logic [GAM_W-1:0]        xc_next  [NUM_CH];
    logic [BP_W-1:0]         bp_next  [NUM_CH];
    logic signed [CP_W-1:0]  cp_next  [NUM_CH];
    logic signed [XF_W-1:0]  xf_next  [NUM_CH];
    logic [DIFF_W-1:0]       diff_next[NUM_CH];
    logic [D3_W-1:0]         d3_next;
    logic [CH_W-1:0]         out_next [NUM_CH];
    logic [MAG_W-1:0]        mag      [NUM_CH];

    logic [AV_W-1:0]         vib_abs;
    logic                    vib_neg;

    assign vib_neg = vib_reg[VIB_W-1];
    assign vib_abs = vib_neg ? (~vib_reg + AV_W'(1)) : vib_reg;

    // Gamma product and gamma round
    always_comb begin
        logic [Q8_W-1:0] x0;
        logic [GP_W:0]   gsum;
        for (int i = 0; i < NUM_CH; i++) begin
            x0 = {pix_in[i], FRAC_W'(0)};
            gp_next[i] = mask_reg[EN_GAMMA] ? GP_W'(x0) * GP_W'(gsq_reg)
                                            : GP_W'(x0) << DIV_SH;
            gsum = (GP_W+1)'(gp_reg[i]) + GP_HALF;
            gam_next[i] = gsum[DIV_SH +: GAM_W];
        end
    end

    // Luma sum, desaturate select and brightness product
    always_comb begin
        logic [DP_W:0]      dsum;
        logic [GAM_W-1:0]   gray;
        dsum = (DP_W+1)'(dp_reg[0]) + (DP_W+1)'(dp_reg[1]) + (DP_W+1)'(dp_reg[2]) + DP_HALF;
        gray = dsum[DIV_SH +: GAM_W];
        for (int i = 0; i < NUM_CH; i++) begin
            xc_next[i] = mask_reg[EN_DESAT] ? gray : gam_reg[i];
            bp_next[i] = mask_reg[EN_BRIGHT] ? BP_W'(xc_reg[i]) * BP_W'(bgain_reg)
                                             : BP_W'(xc_reg[i]) << FRAC_W;
        end
    end

    // Brightness round, contrast about mid-gray
    always_comb begin
        logic [BP_W:0]          bsum;
        logic signed [CD_W-1:0] cdiff;
        logic signed [CP_W-1:0] cg_s;
        logic signed [CP_W-1:0] csum;
        logic signed [CP_W-1:0] csh;
        cg_s = CP_W'($signed({1'b0, cgain_reg}));
        for (int i = 0; i < NUM_CH; i++) begin
            bsum  = (BP_W+1)'(bp_reg[i]) + BP_HALF;
            cdiff = $signed({1'b0, bsum[FRAC_W +: BRT_W]}) - CD_MID;
            cp_next[i] = mask_reg[EN_CONTRAST] ? CP_W'(cdiff) * cg_s
                                               : CP_W'(cdiff) <<< FRAC_W;
            csum = cp_reg[i] + CP_HALF;
            csh  = csum >>> FRAC_W;
            xf_next[i] = XF_W'(csh + CP_MID);
        end
    end

    // Vibrance setup: maximum, d3 = 3*max - sum, distance of each channel to max
    always_comb begin
        logic signed [XF_W-1:0] mx;
        logic signed [XF_W+2:0] mx_ext;
        logic signed [XF_W+2:0] sum3;
        logic signed [XF_W+2:0] d3_full;
        logic signed [XF_W:0]   dfull;
        mx = xf_reg[0];
        if (xf_reg[1] > mx) begin
            mx = xf_reg[1];
        end
        if (xf_reg[2] > mx) begin
            mx = xf_reg[2];
        end
        mx_ext  = (XF_W+3)'(mx);
        sum3    = (XF_W+3)'(xf_reg[0]) + (XF_W+3)'(xf_reg[1]) + (XF_W+3)'(xf_reg[2]);
        d3_full = (mx_ext <<< 1) + mx_ext - sum3;
        d3_next = D3_W'(d3_full);
        for (int i = 0; i < NUM_CH; i++) begin
            // a channel equal to the maximum gets zero distance and so no change
            dfull = (XF_W+1)'(mx) - (XF_W+1)'(xf_reg[i]);
            diff_next[i] = DIFF_W'(dfull);
        end
    end

    // Apply vibrance, round to integer and saturate to 0..255
    always_comb begin
        logic [MAG_W-1:0]       magv;
        logic signed [NC_W-1:0] mag_s;
        logic signed [NC_W-1:0] nc;
        logic signed [NC_W-1:0] o;
        for (int i = 0; i < NUM_CH; i++) begin
            magv  = mask_reg[EN_VIB] ? mag[i] : '0;
            mag_s = $signed(NC_W'(magv));
            nc    = vib_neg ? NC_W'(cv_reg[LANE_ST][i]) - mag_s
                            : NC_W'(cv_reg[LANE_ST][i]) + mag_s;
            o     = (nc + NC_HALF) >>> FRAC_W;
            if (o[NC_W-1]) begin
                out_next[i] = '0;
            end else if (|o[NC_W-2:CH_W]) begin
                out_next[i] = '1;
            end else begin
                out_next[i] = o[CH_W-1:0];
            end
        end
    end

    // Stage registers: hold while stalled, load when the stage advances
    always_ff @(posedge aclk) begin
        for (int i = 0; i < NUM_CH; i++) begin
            if (en[ST_GAMMA]) begin
                gp_reg[i] <= gp_next[i];
            end
            if (en[ST_DESAT]) begin
                gam_reg[i] <= gam_next[i];
                dp_reg[i]  <= DP_W'(gam_next[i]) * DP_W'(LUMA[i]);
            end
            if (en[ST_MIX]) begin
                xc_reg[i] <= xc_next[i];
            end
            if (en[ST_BRIGHT]) begin
                bp_reg[i] <= bp_next[i];
            end
            if (en[ST_CONTR]) begin
                cp_reg[i] <= cp_next[i];
            end
            if (en[ST_CRND]) begin
                xf_reg[i] <= xf_next[i];
            end
            if (en[ST_VSETUP]) begin
                diff_reg[i]  <= diff_next[i];
                cv_reg[0][i] <= xf_reg[i];
            end
            for (int j = 1; j <= LANE_ST; j++) begin
                if (en[ST_LANE + j - 1]) begin
                    cv_reg[j][i] <= cv_reg[j-1][i];
                end
            end
            if (en[ST_OUT]) begin
                out_reg[i] <= out_next[i];
            end
        end
        if (en[ST_VSETUP]) begin
            d3_reg <= d3_next;
        end
    end

    // Vibrance magnitude, one lane per channel, in step with the channel copies
    pca_lane_ctl_t lane_ctl;
    assign lane_ctl.en  = en[ST_LANE +: LANE_ST];
    assign lane_ctl.vld = vld_reg[ST_LANE +: LANE_ST];

    for (genvar g = 0; g < NUM_CH; g++) begin : g_lane
        pca_vib_lane u_lane (
            .aclk    (aclk),
            .aresetn (aresetn),
            .ctl     (lane_ctl),
            .diff    (diff_reg[g]),
            .d3      (d3_reg),
            .vib_abs (vib_abs),
            .mag     (mag[g])
        );
    end

    assign m_red_out   = out_reg[0];
    assign m_green_out = out_reg[1];
    assign m_blue_out  = out_reg[2];

    // The input is refused only when every stage holds a pixel
    a_ready_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> &vld_reg)
        else $error("input refused while a pipeline stage is empty");

    // A full pipeline stalled at the output keeps every pixel
    a_full_stall_keeps: assert property (@(posedge aclk) disable iff (!aresetn)
        (&vld_reg) && !m_ready |=> &vld_reg)
        else $error("pixel lost during output stall");

    // d3 is the sum of the three distances to the maximum
    a_d3_covers_diff: assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[ST_VSETUP] |-> (d3_reg >= D3_W'(diff_reg[0])) &&
                               (d3_reg >= D3_W'(diff_reg[1])) &&
                               (d3_reg >= D3_W'(diff_reg[2])))
        else $error("vibrance d3 below a channel distance");

endmodule
